/* rtl/pbsc_pkg.sv */
package pbsc_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned NORM_W   = 18;
  localparam int unsigned EPS_W    = 31;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_W   = 16;
  // offset +/- tolerance, exact
  localparam int unsigned THR_W    = COORD_W + 2;
  // one normal * coordinate product
  localparam int unsigned PROD_W   = NORM_W + COORD_W;
  // sum of three products
  localparam int unsigned SUM_W    = PROD_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_AXIAL_KIND   = 3'd4,
    REG_TOLERANCE    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axial_t;

  localparam logic signed [NORM_W-1:0] NORMAL_X_RST     = 18'sd0;
  localparam logic signed [NORM_W-1:0] NORMAL_Y_RST     = 18'sd0;
  localparam logic signed [NORM_W-1:0] NORMAL_Z_RST     = 18'sd65536;
  localparam logic signed [COORD_W-1:0] PLANE_OFFSET_RST = 32'sd0;
  localparam logic [EPS_W-1:0] TOLERANCE_RST = 31'd0;

endpackage

/* rtl/pbsc_box_if.sv */
interface pbsc_box_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pbsc_pkg::COORD_W-1:0]   min_x;
  logic signed [pbsc_pkg::COORD_W-1:0]   min_y;
  logic signed [pbsc_pkg::COORD_W-1:0]   min_z;
  logic signed [pbsc_pkg::COORD_W-1:0]   max_x;
  logic signed [pbsc_pkg::COORD_W-1:0]   max_y;
  logic signed [pbsc_pkg::COORD_W-1:0]   max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

/* rtl/pbsc_side_if.sv */
interface pbsc_side_if;
  logic valid;
  logic ready;
  logic front_hit;
  logic back_hit;

  modport source (output valid, front_hit, back_hit, input ready);
  modport sink   (input valid, front_hit, back_hit, output ready);
endinterface

/* rtl/plane_box_side_classify.sv */
// Throughput: one box per cycle when out_ch.ready allows; four register stages
// (corner select, multiply, three-way sum, compare/output) each hold their item
// under stall. Empty stages fill while a later stage is stalled.
// Reset (rst_n low, synchronous): all stage valids clear and the plane
// registers return to normal (0,0,1), offset 0, non-axial, tolerance 0.
module plane_box_side_classify (
  input  logic                              clk,
  input  logic                              rst_n,
  pbsc_box_if.sink                          in_ch,
  pbsc_side_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [pbsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbsc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned CW = pbsc_pkg::COORD_W;
  localparam int unsigned NW = pbsc_pkg::NORM_W;
  localparam int unsigned EW = pbsc_pkg::EPS_W;
  localparam int unsigned TW = pbsc_pkg::THR_W;
  localparam int unsigned PW = pbsc_pkg::PROD_W;
  localparam int unsigned SW = pbsc_pkg::SUM_W;
  localparam int unsigned FW = pbsc_pkg::FRAC_W;

  // plane registers
  logic signed [NW-1:0] normal_x_r, normal_y_r, normal_z_r;
  logic signed [CW-1:0] plane_offset_r;
  pbsc_pkg::axial_t     axial_kind_r;
  logic [EW-1:0]        tolerance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_x_r     <= pbsc_pkg::NORMAL_X_RST;
      normal_y_r     <= pbsc_pkg::NORMAL_Y_RST;
      normal_z_r     <= pbsc_pkg::NORMAL_Z_RST;
      plane_offset_r <= pbsc_pkg::PLANE_OFFSET_RST;
      axial_kind_r   <= pbsc_pkg::AXIS_NONE;
      tolerance_r    <= pbsc_pkg::TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pbsc_pkg::REG_NORMAL_X:     normal_x_r     <= $signed(cfg_wdata[NW-1:0]);
        pbsc_pkg::REG_NORMAL_Y:     normal_y_r     <= $signed(cfg_wdata[NW-1:0]);
        pbsc_pkg::REG_NORMAL_Z:     normal_z_r     <= $signed(cfg_wdata[NW-1:0]);
        pbsc_pkg::REG_PLANE_OFFSET: plane_offset_r <= $signed(cfg_wdata[CW-1:0]);
        pbsc_pkg::REG_AXIAL_KIND:   axial_kind_r   <= pbsc_pkg::axial_t'(cfg_wdata[1:0]);
        pbsc_pkg::REG_TOLERANCE:    tolerance_r    <= cfg_wdata[EW-1:0];
        default: ;
      endcase
    end
  end

  // offset +/- tolerance, both exact in THR_W bits
  logic signed [TW-1:0] thr_hi, thr_lo;
  assign thr_hi = TW'(plane_offset_r) + $signed({{(TW-EW){1'b0}}, tolerance_r});
  assign thr_lo = TW'(plane_offset_r) - $signed({{(TW-EW){1'b0}}, tolerance_r});

  // per-stage load enables
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic en_out, en3, en2, en1;

  assign en_out = !out_valid_r || out_ch.ready;
  assign en3    = !s3_valid_r  || en_out;
  assign en2    = !s2_valid_r  || en3;
  assign en1    = !s1_valid_r  || en2;
  assign in_ch.ready = en1;

  // stage 1: corner select
  logic signed [CW-1:0] s1_far_x_r, s1_far_y_r, s1_far_z_r;
  logic signed [CW-1:0] s1_near_x_r, s1_near_y_r, s1_near_z_r;
  logic signed [CW-1:0] s1_ax_max_r, s1_ax_min_r;
  logic                 s1_axial_r;
  logic signed [CW-1:0] ax_max_nxt, ax_min_nxt;

  always_comb begin
    case (axial_kind_r)
      pbsc_pkg::AXIS_X: begin
        ax_max_nxt = in_ch.max_x;
        ax_min_nxt = in_ch.min_x;
      end
      pbsc_pkg::AXIS_Y: begin
        ax_max_nxt = in_ch.max_y;
        ax_min_nxt = in_ch.min_y;
      end
      default: begin
        ax_max_nxt = in_ch.max_z;
        ax_min_nxt = in_ch.min_z;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      s1_far_x_r  <= normal_x_r[NW-1] ? in_ch.min_x : in_ch.max_x;
      s1_near_x_r <= normal_x_r[NW-1] ? in_ch.max_x : in_ch.min_x;
      s1_far_y_r  <= normal_y_r[NW-1] ? in_ch.min_y : in_ch.max_y;
      s1_near_y_r <= normal_y_r[NW-1] ? in_ch.max_y : in_ch.min_y;
      s1_far_z_r  <= normal_z_r[NW-1] ? in_ch.min_z : in_ch.max_z;
      s1_near_z_r <= normal_z_r[NW-1] ? in_ch.max_z : in_ch.min_z;
      s1_ax_max_r <= ax_max_nxt;
      s1_ax_min_r <= ax_min_nxt;
      s1_axial_r  <= (axial_kind_r != pbsc_pkg::AXIS_NONE);
    end
  end

  // stage 2: products, axial compares
  logic signed [PW-1:0] s2_pf_x_r, s2_pf_y_r, s2_pf_z_r;
  logic signed [PW-1:0] s2_pn_x_r, s2_pn_y_r, s2_pn_z_r;
  logic                 s2_axial_r, s2_ax_front_r, s2_ax_back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      s2_pf_x_r     <= PW'(normal_x_r) * PW'(s1_far_x_r);
      s2_pf_y_r     <= PW'(normal_y_r) * PW'(s1_far_y_r);
      s2_pf_z_r     <= PW'(normal_z_r) * PW'(s1_far_z_r);
      s2_pn_x_r     <= PW'(normal_x_r) * PW'(s1_near_x_r);
      s2_pn_y_r     <= PW'(normal_y_r) * PW'(s1_near_y_r);
      s2_pn_z_r     <= PW'(normal_z_r) * PW'(s1_near_z_r);
      s2_axial_r    <= s1_axial_r;
      s2_ax_front_r <= TW'(s1_ax_max_r) > thr_hi;
      s2_ax_back_r  <= TW'(s1_ax_min_r) < thr_lo;
    end
  end

  // stage 3: dot products
  logic signed [SW-1:0] s3_far_r, s3_near_r;
  logic                 s3_axial_r, s3_ax_front_r, s3_ax_back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en3) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid_r) begin
      s3_far_r      <= SW'(s2_pf_x_r) + SW'(s2_pf_y_r) + SW'(s2_pf_z_r);
      s3_near_r     <= SW'(s2_pn_x_r) + SW'(s2_pn_y_r) + SW'(s2_pn_z_r);
      s3_axial_r    <= s2_axial_r;
      s3_ax_front_r <= s2_ax_front_r;
      s3_ax_back_r  <= s2_ax_back_r;
    end
  end

  // stage 4: d - offset vs tolerance, both sides scaled: dot vs (offset+tol) << 16
  logic signed [SW-1:0] thr_scaled;
  logic                 front_nxt, back_nxt;
  logic                 out_front_r, out_back_r;

  assign thr_scaled = SW'($signed({thr_hi, {FW{1'b0}}}));
  assign front_nxt  = s3_axial_r ? s3_ax_front_r : (s3_far_r >= thr_scaled);
  assign back_nxt   = s3_axial_r ? s3_ax_back_r  : (s3_near_r < thr_scaled);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s3_valid_r) begin
      out_front_r <= front_nxt;
      out_back_r  <= back_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.front_hit = out_front_r;
  assign out_ch.back_hit  = out_back_r;

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_valid_r)
    else $error("accepted box did not reach stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !en2 |=> s1_valid_r && $stable(s1_far_x_r) && $stable(s1_near_z_r))
    else $error("stage 1 changed while stalled");

  a_s2_to_s3: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && en3 |=> s3_valid_r)
    else $error("stage 2 item lost");

  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && en_out |=> out_valid_r)
    else $error("stage 3 item lost");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !en_out |=> s3_valid_r && $stable(s3_far_r) && $stable(s3_near_r))
    else $error("stage 3 changed while stalled");

endmodule

/* dv/plane_box_side_classify_tb.sv */
module plane_box_side_classify_tb;
  import pbsc_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic front_hit;
    logic back_hit;
  } side_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam logic signed [COORD_W-1:0] CMAX     = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] CMIN     = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] Q_ONE    = 32'sd65536;
  localparam logic signed [NORM_W-1:0]  UNIT     = 18'sd65536;
  localparam logic signed [NORM_W-1:0]  NEG_UNIT = -18'sd65536;
  localparam logic signed [NORM_W-1:0]  NORM_MAX = 18'sd131071;
  localparam logic signed [NORM_W-1:0]  NORM_MIN = -18'sd131072;
  localparam logic [EPS_W-1:0]          EPS_MAX  = 31'h7fffffff;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int SPREAD          = 32'h20000;
  localparam int PHASES          = 13;
  localparam int BOXES_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 400000;

  class side_scoreboard;
    logic signed [NORM_W-1:0]  normal [3];
    logic signed [COORD_W-1:0] offset;
    axial_t                    kind;
    logic [EPS_W-1:0]          tol;
    side_t                     side_q [$];
    int                        errors;

    function new();
      normal[0] = NORMAL_X_RST;
      normal[1] = NORMAL_Y_RST;
      normal[2] = NORMAL_Z_RST;
      offset    = PLANE_OFFSET_RST;
      kind      = AXIS_NONE;
      tol       = TOLERANCE_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_NORMAL_X:     normal[0] = data[NORM_W-1:0];
        REG_NORMAL_Y:     normal[1] = data[NORM_W-1:0];
        REG_NORMAL_Z:     normal[2] = data[NORM_W-1:0];
        REG_PLANE_OFFSET: offset = data[COORD_W-1:0];
        REG_AXIAL_KIND:   kind = axial_t'(data[1:0]);
        REG_TOLERANCE:    tol = data[EPS_W-1:0];
        default: ;
      endcase
    endfunction

    function side_t classify(box_t b);
      longint lo [3];
      longint hi [3];
      longint nv [3];
      longint plane_d, margin, far_d, near_d;
      side_t  r;
      lo[0] = longint'(b.min_x); lo[1] = longint'(b.min_y); lo[2] = longint'(b.min_z);
      hi[0] = longint'(b.max_x); hi[1] = longint'(b.max_y); hi[2] = longint'(b.max_z);
      plane_d = longint'(offset);
      margin  = longint'(tol);
      if (kind != AXIS_NONE) begin
        r.front_hit = hi[int'(kind)] > plane_d + margin;
        r.back_hit  = lo[int'(kind)] < plane_d - margin;
      end else begin
        far_d  = 0;
        near_d = 0;
        for (int i = 0; i < 3; i++) begin
          nv[i] = longint'(normal[i]);
          if (nv[i] < 0) begin
            far_d  += nv[i] * lo[i];
            near_d += nv[i] * hi[i];
          end else begin
            far_d  += nv[i] * hi[i];
            near_d += nv[i] * lo[i];
          end
        end
        far_d  -= plane_d <<< FRAC_W;
        near_d -= plane_d <<< FRAC_W;
        r.front_hit = far_d >= (margin <<< FRAC_W);
        // back test uses +tolerance on purpose
        r.back_hit  = near_d < (margin <<< FRAC_W);
      end
      return r;
    endfunction

    function void note_box(box_t b);
      side_q.push_back(classify(b));
    endfunction

    function void check_side(side_t got);
      side_t want;
      if (side_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got front %0b back %0b",
                 $time, got.front_hit, got.back_hit);
        errors++;
        return;
      end
      want = side_q.pop_front();
      if (got.front_hit !== want.front_hit) begin
        $display("%0t: front_hit expected %0b got %0b", $time, want.front_hit, got.front_hit);
        errors++;
      end
      if (got.back_hit !== want.back_hit) begin
        $display("%0t: back_hit expected %0b got %0b", $time, want.back_hit, got.back_hit);
        errors++;
      end
    endfunction

    function int pending();
      return side_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   cycle_count = 0;
  side_scoreboard       sb;

  pbsc_box_if  box_ch ();
  pbsc_side_if side_ch ();

  plane_box_side_classify dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (box_ch),
    .out_ch    (side_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    side_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && box_ch.valid === 1'b1 && box_ch.ready === 1'b1) begin
      sb.note_box('{box_ch.min_x, box_ch.min_y, box_ch.min_z,
                    box_ch.max_x, box_ch.max_y, box_ch.max_z});
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && side_ch.valid === 1'b1 && side_ch.ready === 1'b1) begin
      sb.check_side('{side_ch.front_hit, side_ch.back_hit});
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[plane_box_side_classify] ERROR");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 55;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 55;
      end
      default: begin
        send_idle_pct = 34;
        stall_pct = 34;
      end
    endcase
  endtask

  // valid is left high after a transfer so back-to-back boxes need no second edit
  task automatic send_box(input box_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(posedge clk);
    end
    box_ch.valid <= 1'b1;
    box_ch.min_x <= b.min_x;
    box_ch.min_y <= b.min_y;
    box_ch.min_z <= b.min_z;
    box_ch.max_x <= b.max_x;
    box_ch.max_y <= b.max_y;
    box_ch.max_z <= b.max_z;
    @(posedge clk);
    while (box_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic wait_results_idle();
    box_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper bits carry noise that the block must drop
  task automatic apply_plane(input logic signed [NORM_W-1:0] nx, input logic signed [NORM_W-1:0] ny,
                             input logic signed [NORM_W-1:0] nz,
                             input logic signed [COORD_W-1:0] off,
                             input axial_t kind, input logic [EPS_W-1:0] tol);
    logic [CFG_W-1:0] data;
    data = $urandom;
    data[NORM_W-1:0] = nx;
    put_reg(REG_NORMAL_X, data);
    data = $urandom;
    data[NORM_W-1:0] = ny;
    put_reg(REG_NORMAL_Y, data);
    data = $urandom;
    data[NORM_W-1:0] = nz;
    put_reg(REG_NORMAL_Z, data);
    put_reg(REG_PLANE_OFFSET, off);
    data = $urandom;
    data[1:0] = kind;
    put_reg(REG_AXIAL_KIND, data);
    data = $urandom;
    data[EPS_W-1:0] = tol;
    put_reg(REG_TOLERANCE, data);
    put_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input longint centre);
    longint v;
    case ($urandom_range(0, 9))
      0, 1: v = longint'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: v = longint'(CMAX);
          1: v = longint'(CMIN);
          default: v = 0;
        endcase
      end
      3: v = centre + longint'($urandom_range(0, 8)) - 4;
      default: v = centre + longint'($urandom_range(0, 2 * SPREAD)) - longint'(SPREAD);
    endcase
    return v[COORD_W-1:0];
  endfunction

  initial begin
    logic signed [NORM_W-1:0]  n [3];
    logic signed [COORD_W-1:0] off;
    logic [EPS_W-1:0]          tol;
    logic signed [COORD_W-1:0] a, c;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    longint                    centre;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    box_ch.valid = 1'b0;
    box_ch.min_x = '0;
    box_ch.min_y = '0;
    box_ch.min_z = '0;
    box_ch.max_x = '0;
    box_ch.max_y = '0;
    box_ch.max_z = '0;
    side_ch.ready = 1'b0;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // plane after reset: z = 0, no tolerance
    send_box('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_box('{32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd1});
    send_box('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
    send_box('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
    send_box('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
    send_box('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    send_box('{32'sd0, 32'sd0, Q_ONE, 32'sd0, 32'sd0, 2 * Q_ONE});
    send_box('{32'sd0, 32'sd0, -2 * Q_ONE, 32'sd0, 32'sd0, -Q_ONE});
    wait_results_idle();

    // x-axial, thresholds on the exact tolerance edges
    apply_plane(NEG_UNIT, UNIT, NORM_MIN, Q_ONE, AXIS_X, Q_ONE[EPS_W-1:0]);
    send_box('{32'sd0, CMIN, CMAX, 2 * Q_ONE, CMAX, CMIN});
    send_box('{-32'sd1, 32'sd0, 32'sd0, 2 * Q_ONE + 1, 32'sd0, 32'sd0});
    send_box('{CMIN, 32'sd0, 32'sd0, CMAX, 32'sd0, 32'sd0});
    send_box('{CMAX, 32'sd0, 32'sd0, CMIN, 32'sd0, 32'sd0});
    wait_results_idle();

    apply_plane(UNIT, NEG_UNIT, UNIT, CMAX, AXIS_Z, EPS_MAX);
    send_box('{32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, CMAX});
    send_box('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    wait_results_idle();

    // non-axial with out-of-range normal; box on the plane shows the one-sided margin
    apply_plane(NEG_UNIT, NORM_MAX, NORM_MIN, 32'sd0, AXIS_NONE, 31'd1);
    send_box('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_box('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
    send_box('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    send_box('{-Q_ONE, 32'sd3, Q_ONE, Q_ONE, 32'sd7, 2 * Q_ONE});
    wait_results_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_plane(18'sd0, 18'sd0, 18'sd0, 32'sd0, AXIS_X, 31'd0);
        1: apply_plane(UNIT, UNIT, UNIT, CMAX, AXIS_Y, EPS_MAX);
        2: apply_plane(NEG_UNIT, NEG_UNIT, NEG_UNIT, CMIN, AXIS_Z, EPS_MAX);
        3: apply_plane(UNIT, UNIT, UNIT, CMIN, AXIS_NONE, 31'd0);
        4: apply_plane(NEG_UNIT, NEG_UNIT, NEG_UNIT, CMAX, AXIS_NONE, EPS_MAX);
        5: apply_plane(NORM_MIN, NORM_MAX, NORM_MIN, $urandom_range(0, 2 * SPREAD) - SPREAD,
                       AXIS_NONE, EPS_W'($urandom_range(0, 3 * Q_ONE)));
        default: begin
          for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
              0: n[i] = NORM_W'($urandom);
              1: n[i] = '0;
              2: n[i] = $urandom_range(0, 1) ? UNIT : NEG_UNIT;
              default: n[i] = NORM_W'($urandom_range(0, 2 * 65536) - 65536);
            endcase
          end
          case ($urandom_range(0, 4))
            0, 1: off = $urandom_range(0, 2 * SPREAD) - SPREAD;
            2, 3: off = $urandom;
            default: off = $urandom_range(0, 1) ? CMAX : CMIN;
          endcase
          case ($urandom_range(0, 4))
            0: tol = '0;
            1: tol = EPS_W'($urandom);
            2: tol = EPS_MAX;
            default: tol = EPS_W'($urandom_range(0, 3 * Q_ONE));
          endcase
          apply_plane(n[0], n[1], n[2], off, axial_t'($urandom_range(0, 3)), tol);
        end
      endcase
      set_idling(idle_mode_t'(p % 4));

      // coordinates cluster on offset and offset +/- tolerance
      repeat (BOXES_PER_PHASE) begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 2))
            0: centre = longint'(sb.offset) - longint'(sb.tol);
            1: centre = longint'(sb.offset);
            default: centre = longint'(sb.offset) + longint'(sb.tol);
          endcase
          a = pick_coord(centre);
          c = pick_coord(centre);
          if ((a <= c) == ($urandom_range(0, 9) != 0)) begin
            lo[i] = a;
            hi[i] = c;
          end else begin
            lo[i] = c;
            hi[i] = a;
          end
        end
        send_box('{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]});
      end
      wait_results_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[plane_box_side_classify] OK");
    end else begin
      $display("[plane_box_side_classify] ERROR");
    end
    $finish;
  end

endmodule
